// ----- design/three_axis_pid_with_integral_limits_macros.svh -----
// Assertion macros for the three-axis PID top module.
`ifndef THREE_AXIS_PID_WITH_INTEGRAL_LIMITS_MACROS_SVH
`define THREE_AXIS_PID_WITH_INTEGRAL_LIMITS_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define TAPID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tapid: same-cycle check failed");

// Next-cycle implication, clocked on aclk, off during reset
`define TAPID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tapid: next-cycle check failed");

`endif

// ----- design/tapid_pkg.sv -----
// Package: widths, register indexes and defaults for the three-axis PID block.
`timescale 1ns / 1ps

package tapid_pkg;

    // field widths
    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 15;
    localparam int CLAMP_W  = 23;
    localparam int MAXT_W   = 13;
    localparam int SUM_W    = 24;
    localparam int DRIVE_W  = 16;
    localparam int TDRV_W   = 13;

    // stream widths
    localparam int IN_FIELDS = 10;
    localparam int IN_W      = IN_FIELDS * ERR_W;
    localparam int OUT_RAW_W = 2 * DRIVE_W + TDRV_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CLAMP_W;

    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_INT_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_INT_CLAMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_INT_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_INT_CLAMP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CEIL       = 3'd7;

    // register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd4096;
    localparam logic [CLAMP_W-1:0] CLAMP_RST     = 23'd4096;
    localparam logic [MAXT_W-1:0]  MAX_THR_RST   = 13'd4096;

    // module parameter defaults
    localparam int DT_SHIFT_DEF           = 4;
    localparam int PITCH_DEADBAND_DEF     = 20;
    localparam int THROTTLE_INT_CLAMP_DEF = 4096;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// ----- design/tapid_att_loop.sv -----
// Roll/pitch PID datapath: sum update, gated integral, derivative, saturation.
`timescale 1ns / 1ps

module tapid_att_loop #(
    parameter int DT_SHIFT       = tapid_pkg::DT_SHIFT_DEF,
    parameter int PITCH_DEADBAND = tapid_pkg::PITCH_DEADBAND_DEF
) (
    input  tapid_pkg::err_t                    err,
    input  tapid_pkg::err_t                    prev,
    input  tapid_pkg::sum_t                    sum,
    input  tapid_pkg::gain_t                   kp,
    input  tapid_pkg::gain_t                   ki,
    input  tapid_pkg::gain_t                   kd,
    input  logic [tapid_pkg::THR_W-1:0]        threshold,
    input  logic [tapid_pkg::CLAMP_W-1:0]      clamp,
    input  logic                               zone_gate,  // pitch style sum clearing
    output logic signed [tapid_pkg::DRIVE_W-1:0] drive,
    output tapid_pkg::sum_t                    sum_next
);
    import tapid_pkg::*;

    localparam int ABS_W  = ERR_W + 1;
    localparam int ACCS_W = SUM_W + 1;
    localparam int DIF_W  = ERR_W + 1;
    localparam int D_W    = DIF_W + DT_SHIFT;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int I_W    = GAIN_W + ACCS_W;
    localparam int DP_W   = GAIN_W + D_W;
    localparam int ACC_W  = ((DP_W > I_W) ? DP_W : I_W) + 2;

    localparam logic [ABS_W-1:0]          DEADBAND_U = ABS_W'(PITCH_DEADBAND);
    localparam logic signed [ACC_W-1:0]   SAT_HI     = ACC_W'((1 << (DRIVE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]   SAT_LO     = -ACC_W'(1 << (DRIVE_W - 1));

    logic [ABS_W-1:0]         abs_e;
    logic                     in_zone;
    logic                     in_dead;
    err_t                     step;
    logic signed [ACCS_W-1:0] sum_acc;
    logic signed [ACCS_W-1:0] sum_use;
    logic signed [ACCS_W-1:0] lim_hi;
    logic signed [ACCS_W-1:0] lim_lo;
    logic signed [DIF_W-1:0]  diff;
    logic signed [D_W-1:0]    dterm;
    logic signed [P_W-1:0]    p_prod;
    logic signed [I_W-1:0]    i_prod;
    logic signed [DP_W-1:0]   d_prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sh;

    // error magnitude and zone tests
    always_comb begin
        abs_e   = err[ERR_W-1] ? ABS_W'(-DIF_W'(err)) : ABS_W'(err);
        in_zone = abs_e < ABS_W'(threshold);
        in_dead = abs_e <= DEADBAND_U;
    end

    // integral sum with time step as a shift
    always_comb begin
        step    = err >>> DT_SHIFT;
        sum_acc = ACCS_W'(sum) + ACCS_W'(step);
        if (zone_gate && !(in_zone && !in_dead)) begin
            sum_use = '0;
        end else begin
            sum_use = sum_acc;
        end
    end

    // derivative scaled up by the time step
    always_comb begin
        diff  = DIF_W'(err) - DIF_W'(prev);
        dterm = D_W'(diff) <<< DT_SHIFT;
    end

    // products and total
    always_comb begin
        p_prod = kp * err;
        i_prod = ki * sum_use;
        d_prod = kd * dterm;
        acc    = ACC_W'(p_prod) + ACC_W'(d_prod);
        if (in_zone) begin
            acc = acc + ACC_W'(i_prod);
        end
        acc_sh = acc >>> 8;
    end

    // saturate drive to 16 bits
    always_comb begin
        if (acc_sh > SAT_HI) begin
            drive = DRIVE_W'(SAT_HI);
        end else if (acc_sh < SAT_LO) begin
            drive = DRIVE_W'(SAT_LO);
        end else begin
            drive = DRIVE_W'(acc_sh);
        end
    end

    // clamp the stored sum to +-clamp
    always_comb begin
        lim_hi = ACCS_W'($signed({1'b0, clamp}));
        lim_lo = -lim_hi;
        if (sum_use > lim_hi) begin
            sum_next = SUM_W'(lim_hi);
        end else if (sum_use < lim_lo) begin
            sum_next = SUM_W'(lim_lo);
        end else begin
            sum_next = SUM_W'(sum_use);
        end
    end

endmodule

// ----- design/tapid_thr_loop.sv -----
// Throttle PID datapath: unscaled sum and derivative, base add, 0..max clamp.
`timescale 1ns / 1ps

module tapid_thr_loop #(
    parameter int THROTTLE_INT_CLAMP = tapid_pkg::THROTTLE_INT_CLAMP_DEF
) (
    input  tapid_pkg::err_t                 err,
    input  tapid_pkg::err_t                 prev,
    input  tapid_pkg::sum_t                 sum,
    input  tapid_pkg::err_t                 base,
    input  tapid_pkg::gain_t                gain_p,
    input  tapid_pkg::gain_t                gain_i,
    input  tapid_pkg::gain_t                gain_d,
    input  logic [tapid_pkg::MAXT_W-1:0]    throttle_ceil,
    output logic [tapid_pkg::TDRV_W-1:0]    drive,
    output tapid_pkg::sum_t                 sum_next
);
    import tapid_pkg::*;

    localparam int ACCS_W = SUM_W + 1;
    localparam int DIF_W  = ERR_W + 1;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int I_W    = GAIN_W + ACCS_W;
    localparam int DP_W   = GAIN_W + DIF_W;
    localparam int ACC_W  = I_W + 2;

    localparam logic signed [ACCS_W-1:0] LIM_HI = ACCS_W'(THROTTLE_INT_CLAMP);
    localparam logic signed [ACCS_W-1:0] LIM_LO = -LIM_HI;

    logic signed [ACCS_W-1:0] sum_acc;
    logic signed [DIF_W-1:0]  diff;
    logic signed [P_W-1:0]    p_prod;
    logic signed [I_W-1:0]    i_prod;
    logic signed [DP_W-1:0]   d_prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  total;
    logic signed [ACC_W-1:0]  max_s;

    // sum, derivative and products
    always_comb begin
        sum_acc = ACCS_W'(sum) + ACCS_W'(err);
        diff    = DIF_W'(err) - DIF_W'(prev);
        p_prod  = gain_p * err;
        i_prod  = gain_i * sum_acc;
        d_prod  = gain_d * diff;
        acc     = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);
        total   = (acc >>> 8) + ACC_W'(base);
    end

    // clamp throttle to 0..max
    always_comb begin
        max_s = ACC_W'($signed({1'b0, throttle_ceil}));
        if (total < 0) begin
            drive = '0;
        end else if (total > max_s) begin
            drive = TDRV_W'(throttle_ceil);
        end else begin
            drive = TDRV_W'(total);
        end
    end

    // clamp the stored sum
    always_comb begin
        if (sum_acc > LIM_HI) begin
            sum_next = SUM_W'(LIM_HI);
        end else if (sum_acc < LIM_LO) begin
            sum_next = SUM_W'(LIM_LO);
        end else begin
            sum_next = SUM_W'(sum_acc);
        end
    end

endmodule

// ----- design/three_axis_pid_with_integral_limits.sv -----
// An accepted item passes the input register, then the result register; one item per cycle
// unless the result side holds off. Loop state updates as an item passes the input stage.
// With the result side holding off, both stages fill (two items) and s_axis_tready drops.
// Reset (aresetn low, synchronous): stages empty, sums and previous errors zero,
// registers back to their reset values.
`timescale 1ns / 1ps

module three_axis_pid_with_integral_limits #(
    parameter int DT_SHIFT           = tapid_pkg::DT_SHIFT_DEF,
    parameter int PITCH_DEADBAND     = tapid_pkg::PITCH_DEADBAND_DEF,
    parameter int THROTTLE_INT_CLAMP = tapid_pkg::THROTTLE_INT_CLAMP_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tapid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tapid_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // roll_error, pitch_error, speed_error, roll_kp, roll_ki, roll_kd,
    // pitch_kp, pitch_ki, pitch_kd, throttle_feed (16 bits each, from bit 0)
    input  logic [tapid_pkg::IN_W-1:0]         s_axis_tdata,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // roll_drive [15:0], pitch_drive [31:16], throttle_drive [44:32], zero pad
    output logic [tapid_pkg::OUT_W-1:0]        m_axis_tdata
);
    import tapid_pkg::*;

    `include "three_axis_pid_with_integral_limits_macros.svh"

    // configuration registers
    gain_t              thr_gain_p_reg;
    gain_t              thr_gain_i_reg;
    gain_t              thr_gain_d_reg;
    logic [THR_W-1:0]   roll_thresh_reg;
    logic [CLAMP_W-1:0] roll_clamp_reg;
    logic [THR_W-1:0]   pitch_thresh_reg;
    logic [CLAMP_W-1:0] pitch_clamp_reg;
    logic [MAXT_W-1:0]  max_thr_reg;

    // loop state
    sum_t roll_sum_reg,     roll_sum_next;
    err_t roll_prev_reg;
    sum_t pitch_sum_reg,    pitch_sum_next;
    err_t pitch_prev_reg;
    sum_t throttle_sum_reg, throttle_sum_next;
    err_t throttle_prev_reg;

    // stages
    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;
    logic              advance;
    logic              fire;

    err_t  f_roll_err, f_pitch_err, f_speed_err, f_base;
    gain_t f_roll_kp, f_roll_ki, f_roll_kd, f_pitch_kp, f_pitch_ki, f_pitch_kd;

    logic signed [DRIVE_W-1:0] roll_drive;
    logic signed [DRIVE_W-1:0] pitch_drive;
    logic [TDRV_W-1:0]         throttle_drive;

    // handshake: result stage frees when empty or taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // unpack the staged item
    always_comb begin
        f_roll_err  = in_data_reg[0*ERR_W +: ERR_W];
        f_pitch_err = in_data_reg[1*ERR_W +: ERR_W];
        f_speed_err = in_data_reg[2*ERR_W +: ERR_W];
        f_roll_kp   = in_data_reg[3*ERR_W +: ERR_W];
        f_roll_ki   = in_data_reg[4*ERR_W +: ERR_W];
        f_roll_kd   = in_data_reg[5*ERR_W +: ERR_W];
        f_pitch_kp  = in_data_reg[6*ERR_W +: ERR_W];
        f_pitch_ki  = in_data_reg[7*ERR_W +: ERR_W];
        f_pitch_kd  = in_data_reg[8*ERR_W +: ERR_W];
        f_base      = in_data_reg[9*ERR_W +: ERR_W];
    end

    tapid_att_loop #(
        .DT_SHIFT       (DT_SHIFT),
        .PITCH_DEADBAND (PITCH_DEADBAND)
    ) u_roll (
        .err       (f_roll_err),
        .prev      (roll_prev_reg),
        .sum       (roll_sum_reg),
        .kp        (f_roll_kp),
        .ki        (f_roll_ki),
        .kd        (f_roll_kd),
        .threshold (roll_thresh_reg),
        .clamp     (roll_clamp_reg),
        .zone_gate (1'b0),
        .drive     (roll_drive),
        .sum_next  (roll_sum_next)
    );

    tapid_att_loop #(
        .DT_SHIFT       (DT_SHIFT),
        .PITCH_DEADBAND (PITCH_DEADBAND)
    ) u_pitch (
        .err       (f_pitch_err),
        .prev      (pitch_prev_reg),
        .sum       (pitch_sum_reg),
        .kp        (f_pitch_kp),
        .ki        (f_pitch_ki),
        .kd        (f_pitch_kd),
        .threshold (pitch_thresh_reg),
        .clamp     (pitch_clamp_reg),
        .zone_gate (1'b1),
        .drive     (pitch_drive),
        .sum_next  (pitch_sum_next)
    );

    tapid_thr_loop #(
        .THROTTLE_INT_CLAMP (THROTTLE_INT_CLAMP)
    ) u_throttle (
        .err           (f_speed_err),
        .prev          (throttle_prev_reg),
        .sum           (throttle_sum_reg),
        .base          (f_base),
        .gain_p        (thr_gain_p_reg),
        .gain_i        (thr_gain_i_reg),
        .gain_d        (thr_gain_d_reg),
        .throttle_ceil (max_thr_reg),
        .drive         (throttle_drive),
        .sum_next      (throttle_sum_next)
    );

    // pack the result
    always_comb begin
        out_data_next = OUT_W'({throttle_drive, pitch_drive, roll_drive});
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_gain_p_reg   <= '0;
            thr_gain_i_reg   <= '0;
            thr_gain_d_reg   <= '0;
            roll_thresh_reg  <= THRESHOLD_RST;
            roll_clamp_reg   <= CLAMP_RST;
            pitch_thresh_reg <= THRESHOLD_RST;
            pitch_clamp_reg  <= CLAMP_RST;
            max_thr_reg      <= MAX_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_THROTTLE_GAIN_P:     thr_gain_p_reg   <= cfg_data[GAIN_W-1:0];
                REG_THROTTLE_GAIN_I:     thr_gain_i_reg   <= cfg_data[GAIN_W-1:0];
                REG_THROTTLE_GAIN_D:     thr_gain_d_reg   <= cfg_data[GAIN_W-1:0];
                REG_ROLL_INT_THRESHOLD:  roll_thresh_reg  <= cfg_data[THR_W-1:0];
                REG_ROLL_INT_CLAMP:      roll_clamp_reg   <= cfg_data[CLAMP_W-1:0];
                REG_PITCH_INT_THRESHOLD: pitch_thresh_reg <= cfg_data[THR_W-1:0];
                REG_PITCH_INT_CLAMP:     pitch_clamp_reg  <= cfg_data[CLAMP_W-1:0];
                REG_THROTTLE_CEIL:       max_thr_reg      <= cfg_data[MAXT_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // loop state moves as an item passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_sum_reg      <= '0;
            roll_prev_reg     <= '0;
            pitch_sum_reg     <= '0;
            pitch_prev_reg    <= '0;
            throttle_sum_reg  <= '0;
            throttle_prev_reg <= '0;
        end else if (fire) begin
            roll_sum_reg      <= roll_sum_next;
            roll_prev_reg     <= f_roll_err;
            pitch_sum_reg     <= pitch_sum_next;
            pitch_prev_reg    <= f_pitch_err;
            throttle_sum_reg  <= throttle_sum_next;
            throttle_prev_reg <= f_speed_err;
        end
    end

    // checks
    `TAPID_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid)
    `TAPID_ASSERT_NEXT(a_stalled_stage_holds, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg))
    `TAPID_ASSERT_NEXT(a_state_idle_holds, !fire, $stable(roll_sum_reg) && $stable(pitch_sum_reg) && $stable(throttle_sum_reg))
    `TAPID_ASSERT_NEXT(a_prev_follows_item, fire, roll_prev_reg == $past(f_roll_err))
    `TAPID_ASSERT_NOW(a_throttle_sum_bound, 1'b1, (throttle_sum_reg <= SUM_W'(THROTTLE_INT_CLAMP)) && (throttle_sum_reg >= -SUM_W'(THROTTLE_INT_CLAMP)))

endmodule
